/* hdl/cpu_arith_flags_unit_assert.svh */
// assertion macros shared by the arithmetic flags unit rtl
// no dependencies; included by files that carry concurrent checks
`ifndef CPU_ARITH_FLAGS_UNIT_ASSERT_SVH
`define CPU_ARITH_FLAGS_UNIT_ASSERT_SVH

// property checked on every clock edge outside reset
`define CAFU_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("cafu assertion failed");

// property checked on every clock edge, reset included
`define CAFU_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("cafu assertion failed (no reset gate)");

`endif

/* hdl/cafu_pkg.sv */
// package for the arithmetic flags unit: operation codes and payload structs
// no dependencies; used by cafu_alu and cpu_arith_flags_unit
`timescale 1ns / 1ps

package cafu_pkg;

  localparam int CmdWidth  = 4;
  localparam int WordWidth = 16;
  localparam int ByteWidth = 8;

  typedef enum logic [CmdWidth-1:0] {
    CMD_INC8   = 4'd0,
    CMD_DEC8   = 4'd1,
    CMD_INC16  = 4'd2,
    CMD_DEC16  = 4'd3,
    CMD_ADD8   = 4'd4,
    CMD_SUB8   = 4'd5,
    CMD_ADD16  = 4'd6,
    CMD_ADC8   = 4'd7,
    CMD_ADD_SP = 4'd8
  } cafu_cmd_t;

  typedef struct packed {
    logic zero;
    logic subtract;
    logic half;
    logic carry;
  } cafu_flags_t;

  typedef struct packed {
    logic [CmdWidth-1:0]  cmd;
    logic [WordWidth-1:0] operand_a;
    logic [WordWidth-1:0] operand_b;
    cafu_flags_t          flags;
  } cafu_op_t;

  typedef struct packed {
    logic [WordWidth-1:0] result;
    cafu_flags_t          flags;
  } cafu_res_t;

endpackage

/* hdl/cafu_if.sv */
// valid/ready channel interfaces for operation and result beats
// no dependencies; instanced by whoever connects cpu_arith_flags_unit
`timescale 1ns / 1ps

interface cafu_op_if;
  logic        valid;
  logic        ready;
  logic [3:0]  cmd;
  logic [15:0] operand_a;
  logic [15:0] operand_b;
  logic        zero_in;
  logic        subtract_in;
  logic        half_in;
  logic        carry_in;

  modport source (
    output valid, cmd, operand_a, operand_b, zero_in, subtract_in, half_in, carry_in,
    input  ready
  );
  modport sink (
    input  valid, cmd, operand_a, operand_b, zero_in, subtract_in, half_in, carry_in,
    output ready
  );
endinterface

interface cafu_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] result;
  logic        zero_flag;
  logic        subtract_flag;
  logic        half_carry_flag;
  logic        carry_flag;

  modport source (
    output valid, result, zero_flag, subtract_flag, half_carry_flag, carry_flag,
    input  ready
  );
  modport sink (
    input  valid, result, zero_flag, subtract_flag, half_carry_flag, carry_flag,
    output ready
  );
endinterface

/* hdl/cafu_alu.sv */
// combinational add/sub/inc/dec datapath with flag generation
// depends on cafu_pkg
`timescale 1ns / 1ps

module cafu_alu (
  input  cafu_pkg::cafu_op_t  op,
  output cafu_pkg::cafu_res_t res
);
  import cafu_pkg::*;

  logic [ByteWidth-1:0] a8;
  logic [ByteWidth-1:0] b8;
  logic                 add_cin;
  logic [ByteWidth:0]   sum8;
  logic [4:0]           sum4;
  logic [ByteWidth:0]   diff8;
  logic [ByteWidth-1:0] inc8;
  logic [ByteWidth-1:0] dec8;
  logic [WordWidth:0]   sum16;
  logic [12:0]          sum12;
  logic [WordWidth-1:0] sp_sum;

  assign a8 = op.operand_a[ByteWidth-1:0];
  assign b8 = op.operand_b[ByteWidth-1:0];

  // one byte adder serves add8, adc8 and the low-byte flags of add sp
  assign add_cin = (op.cmd == CMD_ADC8) ? op.flags.carry : 1'b0;
  assign sum8  = {1'b0, a8} + {1'b0, b8} + {{ByteWidth{1'b0}}, add_cin};
  assign sum4  = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, add_cin};
  assign diff8 = {1'b0, a8} - {1'b0, b8};
  assign inc8  = a8 + 8'd1;
  assign dec8  = a8 - 8'd1;
  assign sum16 = {1'b0, op.operand_a} + {1'b0, op.operand_b};
  assign sum12 = {1'b0, op.operand_a[11:0]} + {1'b0, op.operand_b[11:0]};
  assign sp_sum = op.operand_a + {{ByteWidth{b8[7]}}, b8};

  always_comb begin
    res.result = '0;
    res.flags  = op.flags;
    unique case (op.cmd)
      CMD_INC8: begin
        res.result         = {8'd0, inc8};
        res.flags.zero     = (inc8 == 8'd0);
        res.flags.subtract = 1'b0;
        res.flags.half     = (a8[3:0] == 4'hF);
      end
      CMD_DEC8: begin
        res.result         = {8'd0, dec8};
        res.flags.zero     = (dec8 == 8'd0);
        res.flags.subtract = 1'b1;
        res.flags.half     = (a8[3:0] == 4'h0);
      end
      CMD_INC16: res.result = op.operand_a + 16'd1;
      CMD_DEC16: res.result = op.operand_a - 16'd1;
      CMD_ADD8, CMD_ADC8: begin
        res.result         = {8'd0, sum8[ByteWidth-1:0]};
        res.flags.zero     = (sum8[ByteWidth-1:0] == 8'd0);
        res.flags.subtract = 1'b0;
        res.flags.half     = sum4[4];
        res.flags.carry    = sum8[ByteWidth];
      end
      CMD_SUB8: begin
        res.result         = {8'd0, diff8[ByteWidth-1:0]};
        res.flags.zero     = (diff8[ByteWidth-1:0] == 8'd0);
        res.flags.subtract = 1'b1;
        res.flags.half     = (a8[3:0] < b8[3:0]);
        res.flags.carry    = diff8[ByteWidth];
      end
      CMD_ADD16: begin
        res.result         = sum16[WordWidth-1:0];
        res.flags.subtract = 1'b0;
        res.flags.half     = sum12[12];
        res.flags.carry    = sum16[WordWidth];
      end
      CMD_ADD_SP: begin
        // flags from the unsigned low byte, not the sign-extended sum
        res.result         = sp_sum;
        res.flags.zero     = 1'b0;
        res.flags.subtract = 1'b0;
        res.flags.half     = sum4[4];
        res.flags.carry    = sum8[ByteWidth];
      end
      default: begin
        res.result = '0;
        res.flags  = op.flags;
      end
    endcase
  end

endmodule

/* hdl/cpu_arith_flags_unit.sv */
// channel    | dir  | beat contents
// op_chan    | in   | cmd, operand_a, operand_b, zero_in, subtract_in, half_in, carry_in
// res_chan   | out  | result, zero_flag, subtract_flag, half_carry_flag, carry_flag
//
// one beat in per cycle while the result side is not stalled, one result beat out per op beat, passing through
// an input register, the cafu_alu datapath, then the result register.
// rst is synchronous and clears both stage valid bits; payload is not reset.
// a stalled result register holds the input register, and op_chan.ready drops
// only when both stages are full and res_chan.ready is low.
// depends on cafu_pkg, cafu_if, cafu_alu and cpu_arith_flags_unit_assert.svh
`timescale 1ns / 1ps
`include "cpu_arith_flags_unit_assert.svh"

module cpu_arith_flags_unit (
  input logic       clk,
  input logic       rst,
  cafu_op_if.sink   op_chan,
  cafu_res_if.source res_chan
);
  import cafu_pkg::*;

  logic      s1_valid;
  cafu_op_t  s1_op;
  logic      s2_valid;
  cafu_res_t s2_res;
  cafu_res_t alu_res;
  logic      s1_ready;
  logic      s2_ready;
  logic      s1_valid_next;
  logic      s2_valid_next;

  assign s2_ready = !s2_valid || res_chan.ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign op_chan.ready = s1_ready;

  assign s1_valid_next = s1_ready ? op_chan.valid : s1_valid;
  assign s2_valid_next = s2_ready ? s1_valid : s2_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
      s2_valid <= s2_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && op_chan.valid) begin
      s1_op.cmd            <= op_chan.cmd;
      s1_op.operand_a      <= op_chan.operand_a;
      s1_op.operand_b      <= op_chan.operand_b;
      s1_op.flags.zero     <= op_chan.zero_in;
      s1_op.flags.subtract <= op_chan.subtract_in;
      s1_op.flags.half     <= op_chan.half_in;
      s1_op.flags.carry    <= op_chan.carry_in;
    end
  end

  cafu_alu u_alu (
    .op  (s1_op),
    .res (alu_res)
  );

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_res <= alu_res;
    end
  end

  assign res_chan.valid           = s2_valid;
  assign res_chan.result          = s2_res.result;
  assign res_chan.zero_flag       = s2_res.flags.zero;
  assign res_chan.subtract_flag   = s2_res.flags.subtract;
  assign res_chan.half_carry_flag = s2_res.flags.half;
  assign res_chan.carry_flag      = s2_res.flags.carry;

  // a full input stage moves into the result register whenever it has room
  `CAFU_ASSERT(a_s1_advances, clk, rst, (s1_valid && s2_ready) |=> s2_valid)
  // a blocked input stage keeps its beat
  `CAFU_ASSERT(a_s1_holds, clk, rst, (s1_valid && !s2_ready) |=> (s1_valid && $stable(s1_op)))
  // back pressure upstream only when both stages are full and stalled
  `CAFU_ASSERT(a_ready_low_full, clk, rst,
    !op_chan.ready |-> (s1_valid && s2_valid && !res_chan.ready))
  // the cycle after reset both stages are empty
  `CAFU_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> (!s1_valid && !s2_valid))

endmodule
